// ===== rtl/tpl_pkg.sv =====
// Shared types, constants and register codes for the tile peak locator.
package tpl_pkg;

   localparam int MAX_TILES_ACROSS = 16;
   localparam int MAX_TILES_DOWN   = 16;
   localparam int SIZE_LIMIT       = 4096;

   localparam int SIZE_W   = 13;
   localparam int COORD_W  = 12;
   localparam int GRID_W   = 5;
   localparam int PIXEL_W  = 8;
   localparam int TILE_W   = 4;
   localparam int TA_CNT_W = $clog2(MAX_TILES_ACROSS + 1);
   localparam int TD_CNT_W = $clog2(MAX_TILES_DOWN + 1);
   localparam int ENTRY_AW = $clog2(MAX_TILES_ACROSS);

   localparam int CSR_AW = 5;
   localparam int CSR_DW = 32;

   typedef enum logic [2:0] {
      REG_IMAGE_WIDTH  = 3'd0,
      REG_TILE_WIDTH   = 3'd1,
      REG_TILE_HEIGHT  = 3'd2,
      REG_TILES_ACROSS = 3'd3,
      REG_TILES_DOWN   = 3'd4
   } reg_code_type;

   typedef struct packed {
      logic [PIXEL_W-1:0] value;
      logic [COORD_W-1:0] column;
      logic [COORD_W-1:0] row;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef struct packed {
      logic [SIZE_W-1:0]   image_width;
      logic [SIZE_W-1:0]   tile_width;
      logic [SIZE_W-1:0]   tile_height;
      logic [TA_CNT_W-1:0] tiles_across;
      logic [TD_CNT_W-1:0] tiles_down;
   } geometry_type;

   typedef struct packed {
      logic [COORD_W-1:0]  column;
      logic [COORD_W-1:0]  row;
      logic [TA_CNT_W-1:0] tile_column;
      logic [TD_CNT_W-1:0] tile_row;
      logic                in_grid;
      logic                first;
      logic                last;
      logic                frame_last;
   } position_type;

   function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v);
      logic [SIZE_W-1:0] r;
      r = v;
      if (v == '0) begin
         r = SIZE_W'(1);
      end else if (v > SIZE_W'(SIZE_LIMIT)) begin
         r = SIZE_W'(SIZE_LIMIT);
      end
      return r;
   endfunction

endpackage

// ===== rtl/tpl_if.sv =====
// Request and response channel interfaces of the tile peak locator.
interface tpl_req_if;
   import tpl_pkg::*;
   logic               valid;
   logic               ready;
   logic [PIXEL_W-1:0] pixel_value;
   logic               frame_start;

   modport source (output valid, output pixel_value, output frame_start, input ready);
   modport sink (input valid, input pixel_value, input frame_start, output ready);
endinterface

interface tpl_rsp_if;
   import tpl_pkg::*;
   logic               valid;
   logic               ready;
   logic [TILE_W-1:0]  tile_across;
   logic [TILE_W-1:0]  tile_down;
   logic [COORD_W-1:0] peak_column;
   logic [COORD_W-1:0] peak_row;
   logic [PIXEL_W-1:0] peak_value;
   logic               frame_done;

   modport source (output valid, output tile_across, output tile_down, output peak_column,
                   output peak_row, output peak_value, output frame_done, input ready);
   modport sink (input valid, input tile_across, input tile_down, input peak_column,
                 input peak_row, input peak_value, input frame_done, output ready);
endinterface

// ===== rtl/tpl_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
module tpl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== rtl/tpl_raster.sv =====
// Raster position counters that place each pixel in its tile.
module tpl_raster (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  logic                  frame_start,
   input  tpl_pkg::geometry_type geom,
   output tpl_pkg::position_type pos
);
   import tpl_pkg::*;

   logic [COORD_W-1:0]  column_ff, column_in;
   logic [COORD_W-1:0]  row_ff, row_in;
   logic [COORD_W-1:0]  col_tile_ff, col_tile_in;
   logic [COORD_W-1:0]  row_tile_ff, row_tile_in;
   logic [TA_CNT_W-1:0] tcol_ff, tcol_in;
   logic [TD_CNT_W-1:0] trow_ff, trow_in;

   logic [COORD_W-1:0]  column, row, col_tile, row_tile;
   logic [TA_CNT_W-1:0] tcol;
   logic [TD_CNT_W-1:0] trow;
   logic                row_end, col_tile_end, row_tile_end;

   always_comb begin
      column   = frame_start ? '0 : column_ff;
      row      = frame_start ? '0 : row_ff;
      col_tile = frame_start ? '0 : col_tile_ff;
      row_tile = frame_start ? '0 : row_tile_ff;
      tcol     = frame_start ? '0 : tcol_ff;
      trow     = frame_start ? '0 : trow_ff;

      row_end      = ({1'b0, column} + SIZE_W'(1)) >= geom.image_width;
      col_tile_end = ({1'b0, col_tile} + SIZE_W'(1)) >= geom.tile_width;
      row_tile_end = ({1'b0, row_tile} + SIZE_W'(1)) >= geom.tile_height;

      pos.column      = column;
      pos.row         = row;
      pos.tile_column = tcol;
      pos.tile_row    = trow;
      pos.in_grid     = (tcol < geom.tiles_across) && (trow < geom.tiles_down)
                        && (tcol < TA_CNT_W'(MAX_TILES_ACROSS));
      pos.first       = (col_tile == '0) && (row_tile == '0);
      pos.last        = col_tile_end && row_tile_end;
      pos.frame_last  = ((tcol + TA_CNT_W'(1)) == geom.tiles_across)
                        && ((trow + TD_CNT_W'(1)) == geom.tiles_down);

      column_in   = column;
      row_in      = row;
      col_tile_in = col_tile;
      row_tile_in = row_tile;
      tcol_in     = tcol;
      trow_in     = trow;
      if (row_end) begin
         column_in   = '0;
         col_tile_in = '0;
         tcol_in     = '0;
         row_in      = row + COORD_W'(1);
         if (row_tile_end) begin
            row_tile_in = '0;
            if (trow < geom.tiles_down) begin
               trow_in = trow + TD_CNT_W'(1);
            end
         end else begin
            row_tile_in = row_tile + COORD_W'(1);
         end
      end else begin
         column_in = column + COORD_W'(1);
         if (col_tile_end) begin
            col_tile_in = '0;
            if (tcol < geom.tiles_across) begin
               tcol_in = tcol + TA_CNT_W'(1);
            end
         end else begin
            col_tile_in = col_tile + COORD_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff   <= '0;
         row_ff      <= '0;
         col_tile_ff <= '0;
         row_tile_ff <= '0;
         tcol_ff     <= '0;
         trow_ff     <= '0;
      end else if (advance) begin
         column_ff   <= column_in;
         row_ff      <= row_in;
         col_tile_ff <= col_tile_in;
         row_tile_ff <= row_tile_in;
         tcol_ff     <= tcol_in;
         trow_ff     <= trow_in;
      end
   end
endmodule

// ===== rtl/tile_peak_locator.sv =====
// Top level of the tile peak locator: registers, best-pixel memory and result stage.
//
//   Channel   Direction  Carries
//   req_bus   in         one pixel and its frame start flag per request
//   rsp_bus   out        one tile's peak value and position per response
//   csr_*     in/out     APB-style access to the five geometry registers
//
// One pixel is accepted per clock while results are taken. A request's tile entry is read
// at the accepting edge and updated in the compare stage that follows, so a result is
// registered once the compare stage writes the last pixel of its tile. A request that
// follows a write to the same tile takes the written entry from a bypass register.
// Reset is synchronous and needs no clearing pass. A stalled response holds the compare
// stage only while it holds the last pixel of a tile, and the request channel waits with it.
module tile_peak_locator (
   input  logic                       clock,
   input  logic                       reset,
   tpl_req_if.sink                    req_bus,
   tpl_rsp_if.source                  rsp_bus,
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [tpl_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [tpl_pkg::CSR_DW-1:0] csr_pwdata,
   output logic [tpl_pkg::CSR_DW-1:0] csr_prdata,
   output logic                       csr_pready
);
   import tpl_pkg::*;

   logic [SIZE_W-1:0] image_width_ff, tile_width_ff, tile_height_ff;
   logic [GRID_W-1:0] tiles_across_ff, tiles_down_ff;
   reg_code_type      reg_code;
   logic              csr_write;
   geometry_type      geom;

   position_type      pos;
   logic              accept;
   logic              s1_adv;

   logic                           s1_valid_ff, s1_valid_in;
   logic [PIXEL_W-1:0]             s1_pixel_ff;
   logic [COORD_W-1:0]             s1_column_ff, s1_row_ff;
   logic [ENTRY_AW-1:0]            s1_tile_ff;
   logic [TILE_W-1:0]              s1_trow_ff;
   logic                           s1_first_ff, s1_last_ff, s1_frame_last_ff;
   logic                           s1_seen_ff, s1_fwd_ff;
   entry_type                      fwd_entry_ff;
   logic [MAX_TILES_ACROSS-1:0]    written_ff;

   logic [ENTRY_AW-1:0] rd_addr;
   logic [ENTRY_W-1:0]  rd_data;
   entry_type           base, updated;
   logic                s1_write, same_tile;

   logic                rsp_valid_ff, rsp_valid_in, rsp_load;
   logic [TILE_W-1:0]   rsp_across_ff, rsp_down_ff;
   entry_type           rsp_entry_ff;
   logic                rsp_done_ff;

   assign reg_code  = reg_code_type'(csr_paddr[CSR_AW-1:2]);
   assign csr_write = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= SIZE_W'(640);
         tile_width_ff   <= SIZE_W'(40);
         tile_height_ff  <= SIZE_W'(22);
         tiles_across_ff <= GRID_W'(16);
         tiles_down_ff   <= GRID_W'(16);
      end else if (csr_write) begin
         case (reg_code)
            REG_IMAGE_WIDTH:  image_width_ff  <= csr_pwdata[SIZE_W-1:0];
            REG_TILE_WIDTH:   tile_width_ff   <= csr_pwdata[SIZE_W-1:0];
            REG_TILE_HEIGHT:  tile_height_ff  <= csr_pwdata[SIZE_W-1:0];
            REG_TILES_ACROSS: tiles_across_ff <= csr_pwdata[GRID_W-1:0];
            REG_TILES_DOWN:   tiles_down_ff   <= csr_pwdata[GRID_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_code)
         REG_IMAGE_WIDTH:  csr_prdata = CSR_DW'(image_width_ff);
         REG_TILE_WIDTH:   csr_prdata = CSR_DW'(tile_width_ff);
         REG_TILE_HEIGHT:  csr_prdata = CSR_DW'(tile_height_ff);
         REG_TILES_ACROSS: csr_prdata = CSR_DW'(tiles_across_ff);
         REG_TILES_DOWN:   csr_prdata = CSR_DW'(tiles_down_ff);
         default:          csr_prdata = '0;
      endcase
   end

   always_comb begin
      geom.image_width = clamp_size(image_width_ff);
      geom.tile_width  = clamp_size(tile_width_ff);
      geom.tile_height = clamp_size(tile_height_ff);
      if (tiles_across_ff == '0) begin
         geom.tiles_across = TA_CNT_W'(1);
      end else if (tiles_across_ff > GRID_W'(MAX_TILES_ACROSS)) begin
         geom.tiles_across = TA_CNT_W'(MAX_TILES_ACROSS);
      end else begin
         geom.tiles_across = TA_CNT_W'(tiles_across_ff);
      end
      if (tiles_down_ff == '0) begin
         geom.tiles_down = TD_CNT_W'(1);
      end else if (tiles_down_ff > GRID_W'(MAX_TILES_DOWN)) begin
         geom.tiles_down = TD_CNT_W'(MAX_TILES_DOWN);
      end else begin
         geom.tiles_down = TD_CNT_W'(tiles_down_ff);
      end
   end

   assign s1_adv        = !s1_valid_ff || !s1_last_ff || !rsp_valid_ff || rsp_bus.ready;
   assign req_bus.ready = s1_adv;
   assign accept        = req_bus.valid && s1_adv;

   tpl_raster u_raster (
      .clock       (clock),
      .reset       (reset),
      .advance     (accept),
      .frame_start (req_bus.frame_start),
      .geom        (geom),
      .pos         (pos)
   );

   assign rd_addr = pos.tile_column[ENTRY_AW-1:0];

   tpl_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_TILES_ACROSS)
   ) u_best_ram (
      .clock   (clock),
      .wr_en   (s1_write),
      .wr_addr (s1_tile_ff),
      .wr_data (updated),
      .rd_en   (accept),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      if (s1_first_ff) begin
         base = '0;
      end else if (s1_fwd_ff) begin
         base = fwd_entry_ff;
      end else if (s1_seen_ff) begin
         base = entry_type'(rd_data);
      end else begin
         base = '0;
      end
      updated = base;
      if ((s1_pixel_ff > base.value)
          || ((s1_pixel_ff == base.value) && (s1_column_ff < base.column))) begin
         updated.value  = s1_pixel_ff;
         updated.column = s1_column_ff;
         updated.row    = s1_row_ff;
      end
   end

   assign s1_write  = s1_valid_ff && s1_adv;
   assign same_tile = s1_write && (s1_tile_ff == rd_addr);
   assign rsp_load  = s1_write && s1_last_ff;
   assign s1_valid_in = s1_adv ? (accept && pos.in_grid) : s1_valid_ff;
   assign rsp_valid_in = rsp_load ? 1'b1 : (rsp_valid_ff && !rsp_bus.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         written_ff   <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (s1_write) begin
            written_ff[s1_tile_ff] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pixel_ff      <= req_bus.pixel_value;
         s1_column_ff     <= pos.column;
         s1_row_ff        <= pos.row;
         s1_tile_ff       <= rd_addr;
         s1_trow_ff       <= pos.tile_row[TILE_W-1:0];
         s1_first_ff      <= pos.first;
         s1_last_ff       <= pos.last;
         s1_frame_last_ff <= pos.frame_last;
         s1_seen_ff       <= written_ff[rd_addr] || same_tile;
         s1_fwd_ff        <= same_tile;
         fwd_entry_ff     <= updated;
      end
      if (rsp_load) begin
         rsp_across_ff <= s1_tile_ff;
         rsp_down_ff   <= s1_trow_ff;
         rsp_entry_ff  <= updated;
         rsp_done_ff   <= s1_frame_last_ff;
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.tile_across = rsp_across_ff;
   assign rsp_bus.tile_down   = rsp_down_ff;
   assign rsp_bus.peak_column = rsp_entry_ff.column;
   assign rsp_bus.peak_row    = rsp_entry_ff.row;
   assign rsp_bus.peak_value  = rsp_entry_ff.value;
   assign rsp_bus.frame_done  = rsp_done_ff;
endmodule

// ===== rtl/tpl_checker.sv =====
// Port-level checks on the tile peak locator and the bind that attaches them.
module tpl_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [tpl_pkg::COORD_W-1:0] rsp_peak_column,
   input logic [tpl_pkg::COORD_W-1:0] rsp_peak_row,
   input logic [tpl_pkg::PIXEL_W-1:0] rsp_peak_value,
   input logic                        rsp_frame_done
);
   import tpl_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("Response withdrawn while stalled.");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_peak_value) && $stable(rsp_peak_column)
                                  && $stable(rsp_peak_row) && $stable(rsp_frame_done))
      else $error("Response payload changed while stalled.");

   a_dark_tile: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_peak_value == '0) |-> (rsp_peak_column == '0) && (rsp_peak_row == '0))
      else $error("Dark tile reported away from the origin.");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("Response valid straight after reset.");
endmodule

bind tile_peak_locator tpl_checker u_tpl_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .rsp_peak_column (rsp_bus.peak_column),
   .rsp_peak_row    (rsp_bus.peak_row),
   .rsp_peak_value  (rsp_bus.peak_value),
   .rsp_frame_done  (rsp_bus.frame_done)
);

// ===== dv/tile_peak_locator_checker.sv =====
`timescale 1ns / 100ps
// Checker for the tile peak locator: predicts every tile peak and compares the responses.
module tile_peak_locator_checker (
   input  logic                       clock,
   input  logic                       reset,
   tpl_req_if                         req_bus,
   tpl_rsp_if                         rsp_bus,
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [tpl_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [tpl_pkg::CSR_DW-1:0] csr_pwdata,
   input  logic                       csr_pready,
   output int                         errors,
   output int                         pending
);
   import tpl_pkg::*;

   typedef struct packed {
      logic [TILE_W-1:0]  tile_across;
      logic [TILE_W-1:0]  tile_down;
      logic [COORD_W-1:0] peak_column;
      logic [COORD_W-1:0] peak_row;
      logic [PIXEL_W-1:0] peak_value;
      logic               frame_done;
   } tile_peak_type;

   tile_peak_type expected_peaks[$];

   logic [SIZE_W-1:0] image_width_r;
   logic [SIZE_W-1:0] tile_width_r;
   logic [SIZE_W-1:0] tile_height_r;
   logic [GRID_W-1:0] tiles_across_r;
   logic [GRID_W-1:0] tiles_down_r;

   int best_value  [MAX_TILES_ACROSS];
   int best_column [MAX_TILES_ACROSS];
   int best_row    [MAX_TILES_ACROSS];
   int column_count;
   int row_count;
   int column_in_tile;
   int row_in_tile;
   int tile_column;
   int tile_row;

   function automatic int clamp_to(input int v, input int hi);
      if (v == 0) begin
         return 1;
      end
      if (v > hi) begin
         return hi;
      end
      return v;
   endfunction

   task automatic report(input string msg);
      if (errors < 100) begin
         $display("[%0t] tile peak mismatch: %s", $time, msg);
      end
      errors++;
   endtask

   task automatic check_field(input string name, input logic [COORD_W-1:0] got,
                              input logic [COORD_W-1:0] want);
      if (got !== want) begin
         report($sformatf("%s got %0d, expected %0d", name, got, want));
      end
   endtask

   task automatic clear_position();
      column_count   = 0;
      row_count      = 0;
      column_in_tile = 0;
      row_in_tile    = 0;
      tile_column    = 0;
      tile_row       = 0;
   endtask

   task automatic predict_tile_peak(input logic [PIXEL_W-1:0] pixel, input logic frame_start);
      int w;
      int tw;
      int th;
      int ta;
      int td;
      int t;
      tile_peak_type peak;
      w  = clamp_to(int'(image_width_r), SIZE_LIMIT);
      tw = clamp_to(int'(tile_width_r), SIZE_LIMIT);
      th = clamp_to(int'(tile_height_r), SIZE_LIMIT);
      ta = clamp_to(int'(tiles_across_r), MAX_TILES_ACROSS);
      td = clamp_to(int'(tiles_down_r), MAX_TILES_DOWN);
      if (frame_start) begin
         clear_position();
      end
      if (tile_column < ta && tile_row < td && tile_column < MAX_TILES_ACROSS) begin
         t = tile_column;
         if (column_in_tile == 0 && row_in_tile == 0) begin
            best_value[t]  = 0;
            best_column[t] = 0;
            best_row[t]    = 0;
         end
         if (int'(pixel) > best_value[t] ||
             (int'(pixel) == best_value[t] && column_count < best_column[t])) begin
            best_value[t]  = int'(pixel);
            best_column[t] = column_count & 'hFFF;
            best_row[t]    = row_count & 'hFFF;
         end
         if (column_in_tile + 1 >= tw && row_in_tile + 1 >= th) begin
            peak.tile_across = TILE_W'(t);
            peak.tile_down   = TILE_W'(tile_row);
            peak.peak_column = COORD_W'(best_column[t]);
            peak.peak_row    = COORD_W'(best_row[t]);
            peak.peak_value  = PIXEL_W'(best_value[t]);
            peak.frame_done  = (t + 1 == ta) && (tile_row + 1 == td);
            expected_peaks.push_back(peak);
         end
      end
      if (column_count + 1 >= w) begin
         column_count   = 0;
         column_in_tile = 0;
         tile_column    = 0;
         row_count      = (row_count + 1) & 'hFFF;
         if (row_in_tile + 1 >= th) begin
            row_in_tile = 0;
            if (tile_row < td) begin
               tile_row++;
            end
         end else begin
            row_in_tile++;
         end
      end else begin
         column_count = (column_count + 1) & 'hFFF;
         if (column_in_tile + 1 >= tw) begin
            column_in_tile = 0;
            if (tile_column < ta) begin
               tile_column++;
            end
         end else begin
            column_in_tile++;
         end
      end
   endtask

   always @(posedge clock) begin
      tile_peak_type want;
      if (reset) begin
         image_width_r  = SIZE_W'(640);
         tile_width_r   = SIZE_W'(40);
         tile_height_r  = SIZE_W'(22);
         tiles_across_r = GRID_W'(16);
         tiles_down_r   = GRID_W'(16);
         for (int i = 0; i < MAX_TILES_ACROSS; i++) begin
            best_value[i]  = 0;
            best_column[i] = 0;
            best_row[i]    = 0;
         end
         clear_position();
         expected_peaks.delete();
         errors = 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (reg_code_type'(csr_paddr[CSR_AW-1:2]))
               REG_IMAGE_WIDTH: begin
                  image_width_r = csr_pwdata[SIZE_W-1:0];
               end
               REG_TILE_WIDTH: begin
                  tile_width_r = csr_pwdata[SIZE_W-1:0];
               end
               REG_TILE_HEIGHT: begin
                  tile_height_r = csr_pwdata[SIZE_W-1:0];
               end
               REG_TILES_ACROSS: begin
                  tiles_across_r = csr_pwdata[GRID_W-1:0];
               end
               REG_TILES_DOWN: begin
                  tiles_down_r = csr_pwdata[GRID_W-1:0];
               end
               default: begin
               end
            endcase
         end
         if (req_bus.valid && req_bus.ready) begin
            predict_tile_peak(req_bus.pixel_value, req_bus.frame_start);
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_peaks.size() == 0) begin
               report("response with no request awaiting it");
            end else begin
               want = expected_peaks.pop_front();
               check_field("tile_across", COORD_W'(rsp_bus.tile_across),
                           COORD_W'(want.tile_across));
               check_field("tile_down", COORD_W'(rsp_bus.tile_down),
                           COORD_W'(want.tile_down));
               check_field("peak_column", rsp_bus.peak_column, want.peak_column);
               check_field("peak_row", rsp_bus.peak_row, want.peak_row);
               check_field("peak_value", COORD_W'(rsp_bus.peak_value),
                           COORD_W'(want.peak_value));
               check_field("frame_done", COORD_W'(rsp_bus.frame_done),
                           COORD_W'(want.frame_done));
            end
         end
      end
      pending <= expected_peaks.size();
   end

endmodule

// ===== dv/tile_peak_locator_tb.sv =====
`timescale 1ns / 100ps
// Testbench top for the tile peak locator: clock, reset, stimulus and the final verdict.
module tile_peak_locator_tb;
   import tpl_pkg::*;

   localparam int IDLE_LIMIT    = 1000;
   localparam int DIRECTED_ITEMS = 20;
   localparam int RANDOM_ITEMS  = 1350;
   localparam int FRAME_CAP     = 200;
   localparam logic [PIXEL_W-1:0] DIRECTED_FRAME [17] = '{
      8'd5,   8'd7,   8'd0, 8'd0,
      8'd7,   8'd7,   8'd0, 8'd0,
      8'd255, 8'd255, 8'd1, 8'd3,
      8'd255, 8'd255, 8'd3, 8'd2,
      8'd255
   };

   logic              clock;
   logic              reset;
   logic              csr_psel;
   logic              csr_penable;
   logic              csr_pwrite;
   logic [CSR_AW-1:0] csr_paddr;
   logic [CSR_DW-1:0] csr_pwdata;
   logic [CSR_DW-1:0] csr_prdata;
   logic              csr_pready;

   int errors;
   int pending;
   int sent = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int quiet_cycles = 0;

   tpl_req_if req_if ();
   tpl_rsp_if rsp_if ();

   tile_peak_locator uut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_if),
      .rsp_bus     (rsp_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   tile_peak_locator_checker peak_check (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_if),
      .rsp_bus     (rsp_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_pready  (csr_pready),
      .errors      (errors),
      .pending     (pending)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          csr_psel) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= IDLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic set_idling();
      if (sent < 450) begin
         send_idle_pct = 24;
         recv_idle_pct = 79;
      end else if (sent < 900) begin
         send_idle_pct = 79;
         recv_idle_pct = 24;
      end else begin
         send_idle_pct = 0;
         recv_idle_pct = 0;
      end
   endtask

   task automatic send_pixel(input logic [PIXEL_W-1:0] pixel, input logic frame_start);
      set_idling();
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid       <= 1'b1;
      req_if.pixel_value <= pixel;
      req_if.frame_start <= frame_start;
      @(posedge clock);
      while (!req_if.ready) begin
         @(posedge clock);
      end
      sent++;
   endtask

   // A request that completes no tile may still sit in the compare stage once every
   // response has come, so the drain waits on after the last response.
   task automatic drain();
      req_if.valid <= 1'b0;
      do begin
         @(posedge clock);
      end while (pending != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input reg_code_type code, input int value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_AW'({code, 2'b00});
      csr_pwdata  <= CSR_DW'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      do begin
         @(posedge clock);
      end while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic write_geometry(input int iw, input int tw, input int th, input int ta,
                                 input int td);
      drain();
      write_reg(REG_IMAGE_WIDTH, iw);
      write_reg(REG_TILE_WIDTH, tw);
      write_reg(REG_TILE_HEIGHT, th);
      write_reg(REG_TILES_ACROSS, ta);
      write_reg(REG_TILES_DOWN, td);
   endtask

   function automatic logic [PIXEL_W-1:0] random_pixel();
      case ($urandom_range(3))
         0: return PIXEL_W'($urandom_range(255));
         1: return $urandom_range(1) ? 8'hFF : 8'h00;
         2: return PIXEL_W'($urandom_range(3));
         default: return PIXEL_W'(8'hF0 + $urandom_range(15));
      endcase
   endfunction

   function automatic int pick_size();
      case ($urandom_range(5))
         0: return 0;
         1: return 1;
         2: return 4096;
         3: return 4097;
         4: return 8191;
         default: return $urandom_range(1, 6);
      endcase
   endfunction

   function automatic int pick_count();
      case ($urandom_range(5))
         0: return 0;
         1: return 1;
         2: return 16;
         3: return 17;
         4: return 31;
         default: return $urandom_range(1, 3);
      endcase
   endfunction

   // Mostly whole frames with a leading frame start; some lack it, some are cut
   // short, and a stray frame start now and then restarts the raster.
   task automatic send_frame(input int iw, input int th, input int td);
      int eiw;
      int eth;
      int etd;
      int count;
      logic frame_start;
      eiw = (iw == 0) ? 1 : ((iw > SIZE_LIMIT) ? SIZE_LIMIT : iw);
      eth = (th == 0) ? 1 : ((th > SIZE_LIMIT) ? SIZE_LIMIT : th);
      etd = (td == 0) ? 1 : ((td > MAX_TILES_DOWN) ? MAX_TILES_DOWN : td);
      count = eiw * (eth * etd + int'($urandom_range(1)));
      if (count > FRAME_CAP) begin
         count = FRAME_CAP;
      end
      if ($urandom_range(9) == 0) begin
         count = $urandom_range(1, count);
      end
      for (int i = 0; (i < count) && (sent < DIRECTED_ITEMS + RANDOM_ITEMS); i++) begin
         if (i == 0) begin
            frame_start = ($urandom_range(9) != 0);
         end else begin
            frame_start = ($urandom_range(149) == 0);
         end
         send_pixel(random_pixel(), frame_start);
      end
   endtask

   initial begin
      int iw;
      int tw;
      int th;
      int ta;
      int td;
      int phase;
      reset              <= 1'b1;
      req_if.valid       <= 1'b0;
      req_if.pixel_value <= '0;
      req_if.frame_start <= 1'b0;
      csr_psel           <= 1'b0;
      csr_penable        <= 1'b0;
      csr_pwrite         <= 1'b0;
      csr_paddr          <= '0;
      csr_pwdata         <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      send_pixel(8'hFF, 1'b1);
      send_pixel(8'h00, 1'b0);
      send_pixel(8'h80, 1'b0);
      // A 4 by 4 frame of 2 by 2 tiles: ties decided by column, an all-zero tile,
      // and one pixel below the grid.
      write_geometry(4, 2, 2, 2, 2);
      for (int i = 0; i < 17; i++) begin
         send_pixel(DIRECTED_FRAME[i], i == 0);
      end

      phase = 0;
      while (sent < DIRECTED_ITEMS + RANDOM_ITEMS) begin
         if (phase == 0) begin
            iw = 8191; tw = 1; th = 1; ta = 31; td = 16;
         end else if (phase == 1) begin
            iw = 0; tw = 1; th = 1; ta = 0; td = 31;
         end else if (phase == 2) begin
            iw = 16; tw = 8191; th = 4096; ta = 16; td = 1;
         end else if ($urandom_range(4) == 0) begin
            iw = pick_size();
            tw = pick_size();
            th = pick_size();
            ta = pick_count();
            td = pick_count();
         end else begin
            iw = $urandom_range(1, 16);
            tw = $urandom_range(1, 6);
            th = $urandom_range(1, 3);
            ta = $urandom_range(1, 16);
            td = $urandom_range(1, 3);
         end
         write_geometry(iw, tw, th, ta, td);
         repeat ($urandom_range(1, 3)) send_frame(iw, th, td);
         phase++;
      end

      drain();
      repeat (8) @(posedge clock);
      if (errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
